>>> hdl/rrfc_pkg.sv
package rrfc_pkg;

  localparam int unsigned CW = 24;          // coordinate width
  localparam int unsigned DW = CW + 1;      // difference / magnitude width
  localparam int unsigned PW = 2 * CW;      // dividend and quotient width
  localparam int unsigned EW = PW + 2;      // signed extent-check width
  localparam int unsigned LANE_LAT = PW + 3;
  localparam int unsigned LAT = LANE_LAT + 4;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_HIT  = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_ZERO = 2'd2
  } clip_status_e;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] coord;
    logic [CW-1:0]        tn;
    logic [DW-1:0]        td;
  } side_res_t;

endpackage

>>> hdl/rrfc_side.sv
module rrfc_side (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [rrfc_pkg::CW-1:0] c_i,
  input  logic signed [rrfc_pkg::CW-1:0] s_a_i,
  input  logic signed [rrfc_pkg::DW-1:0] d_a_i,
  input  logic signed [rrfc_pkg::CW-1:0] s_b_i,
  input  logic signed [rrfc_pkg::DW-1:0] d_b_i,
  input  logic signed [rrfc_pkg::CW-1:0] lo_i,
  input  logic signed [rrfc_pkg::CW-1:0] hi_i,
  output rrfc_pkg::side_res_t            res_o
);
  import rrfc_pkg::*;

  typedef struct packed {
    logic                 ok;
    logic                 neg;
    logic signed [CW-1:0] sb;
    logic [CW-1:0]        an;
    logic [DW-1:0]        ad;
    logic [DW-1:0]        rem;
    logic [PW-1:0]        dvd;
    logic [PW-1:0]        quo;
  } dstage_t;

  function automatic dstage_t div_step(dstage_t s);
    dstage_t       o;
    logic [DW:0]   trial;
    logic          take;
    o     = s;
    trial = {s.rem, s.dvd[PW-1]};
    take  = (trial >= {1'b0, s.ad});
    o.rem = take ? DW'(trial - {1'b0, s.ad}) : trial[DW-1:0];
    o.dvd = {s.dvd[PW-2:0], 1'b0};
    o.quo = {s.quo[PW-2:0], take};
    return o;
  endfunction

  // front end: crossing distance and direction magnitudes
  logic signed [DW-1:0] num;
  logic [DW-1:0]        num_mag, ad, mb;
  logic                 ok;

  assign num     = {c_i[CW-1], c_i} - {s_a_i[CW-1], s_a_i};
  assign num_mag = num[DW-1] ? DW'(-num) : DW'(num);
  assign ad      = d_a_i[DW-1] ? DW'(-d_a_i) : DW'(d_a_i);
  assign mb      = d_b_i[DW-1] ? DW'(-d_b_i) : DW'(d_b_i);
  assign ok      = (d_a_i != '0) && (num != '0) && (num[DW-1] == d_a_i[DW-1]);

  logic                 p_ok_q, p_neg_q;
  logic [CW-1:0]        p_an_q;
  logic [DW-1:0]        p_ad_q, p_mb_q;
  logic signed [CW-1:0] p_sb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ok_q  <= ok;
      p_neg_q <= d_b_i[DW-1];
      p_an_q  <= num_mag[CW-1:0];
      p_ad_q  <= ad;
      p_mb_q  <= mb;
      p_sb_q  <= s_b_i;
    end
  end

  logic [DW+CW-1:0] prod;
  assign prod = p_mb_q * p_an_q;

  dstage_t d_q [PW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0].ok  <= p_ok_q;
      d_q[0].neg <= p_neg_q;
      d_q[0].sb  <= p_sb_q;
      d_q[0].an  <= p_an_q;
      d_q[0].ad  <= p_ad_q;
      d_q[0].rem <= '0;
      d_q[0].dvd <= prod[PW-1:0];
      d_q[0].quo <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < PW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k+1] <= div_step(d_q[k]);
      end
    end
  end

  // back end: extent check on the exact crossing, then rounding
  dstage_t              f;
  logic signed [EW-1:0] sb_e, q_e, lo_e, hi_e, base;
  logic                 exact, in_ext, rnd;
  logic [CW-1:0]        rq;
  side_res_t            res_d, res_q;

  always_comb begin
    f      = d_q[PW];
    sb_e   = {{(EW-CW){f.sb[CW-1]}}, f.sb};
    q_e    = {2'b00, f.quo};
    lo_e   = {{(EW-CW){lo_i[CW-1]}}, lo_i};
    hi_e   = {{(EW-CW){hi_i[CW-1]}}, hi_i};
    exact  = (f.rem == '0);
    if (!f.neg) begin
      base   = sb_e + q_e;
      in_ext = !(base < lo_e) && !(exact ? (base > hi_e) : (base >= hi_e));
    end else begin
      base   = sb_e - q_e;
      in_ext = !(base > hi_e) && !(exact ? (base < lo_e) : (base <= lo_e));
    end
    rnd         = ({f.rem, 1'b0} >= {1'b0, f.ad});
    rq          = f.quo[CW-1:0] + CW'(rnd);
    res_d.hit   = f.ok && in_ext;
    res_d.coord = f.neg ? f.sb - $signed(rq) : f.sb + $signed(rq);
    res_d.tn    = f.an;
    res_d.td    = f.ad;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> hdl/ray_rectangle_forward_clip_unit.sv
// Ray / axis-aligned rectangle forward clip.
// Input channel (in_valid_i / in_stall_o) carries a start point and a second
// point; the ray runs from the start toward the second point. The four
// rectangle edges are set through the write port (cfg_we_i, cfg_addr_i,
// cfg_data_i) by the user only while no word is in flight; the block does not enforce it.
// Output channel (out_valid_o / out_stall_i) returns one word per input word:
// the nearest forward crossing (top, bottom, left, right win ties in that
// order), else the start point, or the second point when both points match.
// The pipeline has one front-end stage per side, one multiply stage,
// a 48-stage restoring divider (one quotient bit per stage), one extent-check
// stage, and a two-round compare tree with a multiply and a select stage each.
// Throughput is one word per cycle unless stalled. The whole pipeline advances
// together; a stall on a valid output holds every stage and raises in_stall_o,
// nothing is lost or repeated. Reset clears all valid bits and the edge registers to 0.
module ray_rectangle_forward_clip_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_addr_i,
  input  logic [rrfc_pkg::CW-1:0]        cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [rrfc_pkg::CW-1:0] start_x_i,
  input  logic signed [rrfc_pkg::CW-1:0] start_y_i,
  input  logic signed [rrfc_pkg::CW-1:0] toward_x_i,
  input  logic signed [rrfc_pkg::CW-1:0] toward_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [rrfc_pkg::CW-1:0] hit_x_o,
  output logic signed [rrfc_pkg::CW-1:0] hit_y_o,
  output logic [1:0]                     clip_status_o
);
  import rrfc_pkg::*;

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } common_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [CW-1:0]        tn;
    logic [DW-1:0]        td;
  } cand_t;

  logic signed [CW-1:0] left_q, top_q, right_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          en;
  logic [LAT-1:0] v_q;
  common_t       cm_q [LAT];

  assign en         = !v_q[LAT-1] || !out_stall_i;
  assign in_stall_o = !en;

  logic signed [DW-1:0] dx, dy;
  assign dx = {toward_x_i[CW-1], toward_x_i} - {start_x_i[CW-1], start_x_i};
  assign dy = {toward_y_i[CW-1], toward_y_i} - {start_y_i[CW-1], start_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cm_q[0] <= '{zero: (dx == '0) && (dy == '0), sx: start_x_i, sy: start_y_i,
                   px: toward_x_i, py: toward_y_i};
      for (int i = 1; i < LAT; i++) begin
        cm_q[i] <= cm_q[i-1];
      end
    end
  end

  side_res_t res [4];

  rrfc_side u_top (
    .clk_i, .en_i(en), .c_i(top_q), .s_a_i(start_y_i), .d_a_i(dy),
    .s_b_i(start_x_i), .d_b_i(dx), .lo_i(left_q), .hi_i(right_q), .res_o(res[0])
  );
  rrfc_side u_bottom (
    .clk_i, .en_i(en), .c_i(bottom_q), .s_a_i(start_y_i), .d_a_i(dy),
    .s_b_i(start_x_i), .d_b_i(dx), .lo_i(left_q), .hi_i(right_q), .res_o(res[1])
  );
  rrfc_side u_left (
    .clk_i, .en_i(en), .c_i(left_q), .s_a_i(start_x_i), .d_a_i(dx),
    .s_b_i(start_y_i), .d_b_i(dy), .lo_i(top_q), .hi_i(bottom_q), .res_o(res[2])
  );
  rrfc_side u_right (
    .clk_i, .en_i(en), .c_i(right_q), .s_a_i(start_x_i), .d_a_i(dx),
    .s_b_i(start_y_i), .d_b_i(dy), .lo_i(top_q), .hi_i(bottom_q), .res_o(res[3])
  );

  cand_t cand [4];
  always_comb begin
    cand[0] = '{hit: res[0].hit, x: res[0].coord, y: top_q,    tn: res[0].tn, td: res[0].td};
    cand[1] = '{hit: res[1].hit, x: res[1].coord, y: bottom_q, tn: res[1].tn, td: res[1].td};
    cand[2] = '{hit: res[2].hit, x: left_q,  y: res[2].coord,  tn: res[2].tn, td: res[2].td};
    cand[3] = '{hit: res[3].hit, x: right_q, y: res[3].coord,  tn: res[3].tn, td: res[3].td};
  end

  // round 1: cross-multiplied t compare per pair, later side wins only if strictly nearer
  cand_t              r1a_q [2], r1b_q [2];
  logic [CW+DW-1:0]   r1l_q [2], r1r_q [2];
  cand_t              w1_q  [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        r1a_q[p] <= cand[2*p];
        r1b_q[p] <= cand[2*p+1];
        r1l_q[p] <= cand[2*p+1].tn * cand[2*p].td;
        r1r_q[p] <= cand[2*p].tn * cand[2*p+1].td;
      end
      for (int p = 0; p < 2; p++) begin
        w1_q[p] <= (r1b_q[p].hit && (!r1a_q[p].hit || (r1l_q[p] < r1r_q[p])))
                   ? r1b_q[p] : r1a_q[p];
      end
    end
  end

  cand_t            r2a_q, r2b_q;
  logic [CW+DW-1:0] r2l_q, r2r_q;
  cand_t            win;
  common_t          cm_w;

  assign win  = (r2b_q.hit && (!r2a_q.hit || (r2l_q < r2r_q))) ? r2b_q : r2a_q;
  assign cm_w = cm_q[LAT-2];

  logic signed [CW-1:0] hit_x_q, hit_y_q;
  clip_status_e         status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2a_q <= w1_q[0];
      r2b_q <= w1_q[1];
      r2l_q <= w1_q[1].tn * w1_q[0].td;
      r2r_q <= w1_q[0].tn * w1_q[1].td;
      if (cm_w.zero) begin
        hit_x_q  <= cm_w.px;
        hit_y_q  <= cm_w.py;
        status_q <= STATUS_ZERO;
      end else if (win.hit) begin
        hit_x_q  <= win.x;
        hit_y_q  <= win.y;
        status_q <= STATUS_HIT;
      end else begin
        hit_x_q  <= cm_w.sx;
        hit_y_q  <= cm_w.sy;
        status_q <= STATUS_MISS;
      end
    end
  end

  assign out_valid_o   = v_q[LAT-1];
  assign hit_x_o       = hit_x_q;
  assign hit_y_o       = hit_y_q;
  assign clip_status_o = status_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(v_q))
    else $error("pipeline moved during stall");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0) |-> !in_stall_o)
    else $error("empty pipeline stalls input");

  a_zero_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LANE_LAT-1] && cm_q[LANE_LAT-1].zero) |->
      !(res[0].hit || res[1].hit || res[2].hit || res[3].hit))
    else $error("side hit on zero-length ray");

endmodule
